// ----- design/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/lbp_pkg.sv -----
// Shared constants, types and elaboration-time tables for the uniform LBP core.
`timescale 1ns / 1ps

package lbp_pkg;

    localparam int PIX_W         = 8;
    localparam int LABEL_W       = 6;
    localparam int CODE_W        = 8;
    localparam int WIDTH_CFG_W   = 11;
    localparam int HEIGHT_CFG_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int HEIGHT_W      = 13;
    localparam int DEF_RADIUS    = 2;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int NEIGHBORS     = 8;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int Q8_ONE        = 256;
    localparam int WIN_IDX_W     = 3;
    localparam int WEIGHT_W      = 9;
    localparam int ACC_W         = 17;
    localparam int NUM_CODES     = 256;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef logic [LABEL_W-1:0] label_lut_t [NUM_CODES];

    // Window taps and Q8 bilinear weights of one sample point.
    typedef struct packed {
        logic [WIN_IDX_W-1:0] y1;
        logic [WIN_IDX_W-1:0] x1;
        logic                 dy;
        logic                 dx;
        logic [WEIGHT_W-1:0]  w1;
        logic [WEIGHT_W-1:0]  w2;
        logic [WEIGHT_W-1:0]  w3;
        logic [WEIGHT_W-1:0]  w4;
    } point_geom_t;

    // cos(k*pi/4) in Q8
    function automatic int unit_cos_q8(input int k);
        int v;
        begin
            case (k & 7)
                0:       v = 256;
                1:       v = 181;
                2:       v = 0;
                3:       v = -181;
                4:       v = -256;
                5:       v = -181;
                6:       v = 0;
                7:       v = 181;
                default: v = 0;
            endcase
            return v;
        end
    endfunction

    function automatic point_geom_t point_geom(input int radius, input int k);
        int offx;
        int offy;
        int tx;
        int ty;
        int fx;
        int fy;
        int w1;
        int w2;
        int w3;
        int w4;
        point_geom_t g;
        begin
            offx = radius * unit_cos_q8(k);
            // sin(k*pi/4) = cos((k-2)*pi/4); rows grow downward
            offy = -(radius * unit_cos_q8(k + 6));
            tx   = offx + 1024;
            ty   = offy + 1024;
            fx   = tx & 255;
            fy   = ty & 255;
            w2   = (fx * (Q8_ONE - fy) + 128) >> 8;
            w3   = ((Q8_ONE - fx) * fy + 128) >> 8;
            w4   = (fx * fy + 128) >> 8;
            w1   = Q8_ONE - w2 - w3 - w4;
            g.x1 = WIN_IDX_W'(radius + (tx >> 8) - 4);
            g.y1 = WIN_IDX_W'(radius + (ty >> 8) - 4);
            g.dx = (fx != 0);
            g.dy = (fy != 0);
            g.w1 = WEIGHT_W'(w1);
            g.w2 = WEIGHT_W'(w2);
            g.w3 = WEIGHT_W'(w3);
            g.w4 = WEIGHT_W'(w4);
            return g;
        end
    endfunction

    function automatic int transitions(input int code);
        int n;
        begin
            n = 0;
            for (int i = 0; i < 8; i++)
            begin
                if (((code >> i) & 1) != ((code >> ((i + 1) & 7)) & 1))
                    n++;
            end
            return n;
        end
    endfunction

    // Uniform codes numbered 1.. in ascending code order, the rest 0.
    function automatic label_lut_t build_label_lut();
        label_lut_t lut;
        int lab;
        begin
            lab = 1;
            for (int c = 0; c < NUM_CODES; c++)
            begin
                if (transitions(c) <= 2)
                begin
                    lut[c] = LABEL_W'(lab);
                    lab++;
                end
                else
                begin
                    lut[c] = '0;
                end
            end
            return lut;
        end
    endfunction

    localparam label_lut_t LABEL_LUT = build_label_lut();

endpackage

// ----- design/lbp_line_buf.sv -----
// Line store: one word per column holding the last 2*RADIUS rows, with write-to-read bypass.
`timescale 1ns / 1ps

module lbp_line_buf #(
    parameter int RADIUS    = lbp_pkg::DEF_RADIUS,
    parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
    input  logic                                   wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]           wr_addr,
    input  logic [lbp_pkg::PIX_W-1:0]              wr_pixel,
    output logic [2*RADIUS-1:0][lbp_pkg::PIX_W-1:0] line
);

    localparam int LINES = 2 * RADIUS;

    typedef logic [LINES-1:0][lbp_pkg::PIX_W-1:0] word_t;

    word_t mem [MAX_WIDTH];
    word_t rd_data_reg;
    word_t fwd_reg;
    logic  byp_reg;
    word_t wr_data;

    // column moves up one row; newest pixel enters the bottom line
    always_comb
    begin
        for (int k = 0; k < LINES - 1; k++)
            wr_data[k] = line[k + 1];
        wr_data[LINES-1] = wr_pixel;
    end

    assign line = byp_reg ? fwd_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            fwd_reg     <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_reg <= 1'b0;
        else if (rd_en)
            byp_reg <= wr_en && (wr_addr == rd_addr);
    end

endmodule

// ----- design/lbp_window.sv -----
// Square pixel window, shifted left by one column per pixel.
`timescale 1ns / 1ps

module lbp_window #(
    parameter int RADIUS = lbp_pkg::DEF_RADIUS
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 shift,
    input  logic [2*RADIUS-1:0][lbp_pkg::PIX_W-1:0]              line,
    input  logic [lbp_pkg::PIX_W-1:0]                            pixel,
    output logic [2*RADIUS:0][2*RADIUS:0][lbp_pkg::PIX_W-1:0]    win
);

    localparam int WIN   = 2 * RADIUS + 1;
    localparam int LINES = 2 * RADIUS;

    logic [WIN-1:0][WIN-1:0][lbp_pkg::PIX_W-1:0] win_reg;

    assign win = win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift)
        begin
            for (int y = 0; y < WIN; y++)
                for (int x = 0; x < WIN - 1; x++)
                    win_reg[y][x] <= win_reg[y][x + 1];
            for (int k = 0; k < LINES; k++)
                win_reg[k][WIN-1] <= line[k];
            win_reg[WIN-1][WIN-1] <= pixel;
        end
    end

endmodule

// ----- design/lbp_sampler.sv -----
// Eight interpolated circle samples compared with the centre pixel, giving the LBP code.
`timescale 1ns / 1ps

module lbp_sampler #(
    parameter int RADIUS = lbp_pkg::DEF_RADIUS
) (
    input  logic [2*RADIUS:0][2*RADIUS:0][lbp_pkg::PIX_W-1:0] win,
    output logic [lbp_pkg::CODE_W-1:0]                        code
);

    localparam int ACC_W = lbp_pkg::ACC_W;

    logic [ACC_W-1:0] mid_q8;

    assign mid_q8 = {1'b0, win[RADIUS][RADIUS], 8'd0};

    for (genvar k = 0; k < lbp_pkg::NEIGHBORS; k++)
    begin : g_point
        localparam lbp_pkg::point_geom_t G = lbp_pkg::point_geom(RADIUS, k);
        localparam int X1 = int'(G.x1);
        localparam int Y1 = int'(G.y1);
        localparam int X2 = X1 + int'(G.dx);
        localparam int Y2 = Y1 + int'(G.dy);

        logic [ACC_W-1:0] acc;

        // weights are elaboration constants; sum of weights is 256
        assign acc = ACC_W'(G.w1) * ACC_W'(win[Y1][X1])
                   + ACC_W'(G.w2) * ACC_W'(win[Y1][X2])
                   + ACC_W'(G.w3) * ACC_W'(win[Y2][X1])
                   + ACC_W'(G.w4) * ACC_W'(win[Y2][X2]);

        // point 0 lands in the MSB
        assign code[lbp_pkg::NEIGHBORS - 1 - k] = (acc > mid_q8);
    end

endmodule

// ----- design/uniform_lbp_8_neighbor_core.sv -----
// Top level of the 8-point circular uniform LBP core.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Streams 8-bit gray pixels in raster order, one request per clock, and returns one uniform
// LBP label (0..58) for every pixel whose circle of RADIUS fits inside the frame; the label
// belongs to the pixel RADIUS rows and RADIUS columns behind the input. Sustained rate is one
// pixel per clock while label_stall is low; a label passes the line-store read, window shift,
// sampling and table lookup registers. Widths and heights are clamped to 1..MAX_WIDTH and
// 1..4096; frames no larger than 2*RADIUS in either direction give no labels. frame_start
// restarts the raster position. The line store has no reset and needs no clearing pass;
// image_width and image_height should only be written while the core is idle.
module uniform_lbp_8_neighbor_core #(
    parameter int RADIUS    = lbp_pkg::DEF_RADIUS,
    parameter int MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lbp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [lbp_pkg::PIX_W-1:0]         pixel,
    input  logic                              frame_start,
    output logic                              label_valid,
    input  logic                              label_stall,
    output logic [lbp_pkg::LABEL_W-1:0]       label,
    output logic                              row_end,
    output logic                              frame_end
);

    localparam int WIN   = 2 * RADIUS + 1;
    localparam int LINES = 2 * RADIUS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = lbp_pkg::HEIGHT_W;
    localparam int RW    = lbp_pkg::ROW_W;
    localparam int DW    = lbp_pkg::CFG_DATA_W;
    localparam int WIDTH_RST = (lbp_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                   : lbp_pkg::WIDTH_RESET;

    // configuration, stored already clamped
    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [DW-1:0] width_raw;
    logic [DW-1:0] width_clamped;
    logic [DW-1:0] height_clamped;

    // raster position
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic [WW-1:0] col_plus;
    logic [HW-1:0] row_plus;
    logic          last_col;
    logic          last_row;
    logic          emit;

    // pipeline
    logic                          s1_valid_reg;
    logic [lbp_pkg::PIX_W-1:0]     s1_pixel_reg;
    logic [CW-1:0]                 s1_col_reg;
    logic                          s1_emit_reg;
    logic                          s1_row_end_reg;
    logic                          s1_frame_end_reg;
    logic                          s2_valid_reg;
    logic                          s2_emit_reg;
    logic                          s2_row_end_reg;
    logic                          s2_frame_end_reg;
    logic                          s3_valid_reg;
    logic [lbp_pkg::CODE_W-1:0]    s3_code_reg;
    logic                          s3_row_end_reg;
    logic                          s3_frame_end_reg;
    logic                          label_valid_reg;
    logic [lbp_pkg::LABEL_W-1:0]   label_reg;
    logic                          row_end_reg;
    logic                          frame_end_reg;

    logic out_free;
    logic s3_free;
    logic s2_go;
    logic s2_free;
    logic s1_go;
    logic s1_free;
    logic accept;

    logic [LINES-1:0][lbp_pkg::PIX_W-1:0]        line;
    logic [WIN-1:0][WIN-1:0][lbp_pkg::PIX_W-1:0] win;
    logic [lbp_pkg::CODE_W-1:0]                  code;

    // ---------------- configuration ----------------
    assign width_raw = DW'(cfg_data[lbp_pkg::WIDTH_CFG_W-1:0]);

    always_comb
    begin
        if (width_raw == '0)
            width_clamped = DW'(1);
        else if (width_raw > DW'(MAX_WIDTH))
            width_clamped = DW'(MAX_WIDTH);
        else
            width_clamped = width_raw;

        if (cfg_data == '0)
            height_clamped = DW'(1);
        else if (cfg_data > DW'(lbp_pkg::MAX_HEIGHT))
            height_clamped = DW'(lbp_pkg::MAX_HEIGHT);
        else
            height_clamped = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(WIDTH_RST);
            height_reg <= HW'(lbp_pkg::HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lbp_pkg::CFG_IMAGE_WIDTH:  width_reg  <= width_clamped[WW-1:0];
                lbp_pkg::CFG_IMAGE_HEIGHT: height_reg <= height_clamped[HW-1:0];
                default:                   ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free    = !label_valid_reg || !label_stall;
    assign s3_free     = !s3_valid_reg || out_free;
    assign s2_go       = s2_valid_reg && (!s2_emit_reg || s3_free);
    assign s2_free     = !s2_valid_reg || s2_go;
    assign s1_go       = s1_valid_reg && s2_free;
    assign s1_free     = !s1_valid_reg || s1_go;
    assign pixel_stall = !s1_free;
    assign accept      = pixel_valid && s1_free;

    // ---------------- raster position ----------------
    always_comb
    begin
        col_cur = col_reg;
        row_cur = row_reg;
        if (frame_start)
        begin
            col_cur = '0;
            row_cur = '0;
        end
        // position past a shrunken size wraps
        if (WW'(col_cur) >= width_reg)
            col_cur = '0;
        if (HW'(row_cur) >= height_reg)
            row_cur = '0;

        col_plus = WW'(col_cur) + WW'(1);
        row_plus = HW'(row_cur) + HW'(1);
        last_col = (col_plus >= width_reg);
        last_row = (row_plus >= height_reg);
        emit     = (col_cur >= CW'(LINES)) && (row_cur >= RW'(LINES));

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_plus[RW-1:0];
        end
        else
        begin
            col_next = col_plus[CW-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- datapath units ----------------
    lbp_line_buf #(
        .RADIUS    (RADIUS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (col_cur),
        .wr_en    (s1_go),
        .wr_addr  (s1_col_reg),
        .wr_pixel (s1_pixel_reg),
        .line     (line)
    );

    lbp_window #(
        .RADIUS (RADIUS)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_go),
        .line  (line),
        .pixel (s1_pixel_reg),
        .win   (win)
    );

    lbp_sampler #(
        .RADIUS (RADIUS)
    ) u_sampler (
        .win  (win),
        .code (code)
    );

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            label_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= pixel_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_go && s2_emit_reg;
            if (out_free)
                label_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg     <= pixel;
            s1_col_reg       <= col_cur;
            s1_emit_reg      <= emit;
            s1_row_end_reg   <= last_col;
            s1_frame_end_reg <= last_col && last_row;
        end
        if (s1_go)
        begin
            s2_emit_reg      <= s1_emit_reg;
            s2_row_end_reg   <= s1_row_end_reg;
            s2_frame_end_reg <= s1_frame_end_reg;
        end
        if (s2_go && s2_emit_reg)
        begin
            s3_code_reg      <= code;
            s3_row_end_reg   <= s2_row_end_reg;
            s3_frame_end_reg <= s2_frame_end_reg;
        end
        if (out_free && s3_valid_reg)
        begin
            label_reg     <= lbp_pkg::LABEL_LUT[s3_code_reg];
            row_end_reg   <= s3_row_end_reg;
            frame_end_reg <= s3_frame_end_reg;
        end
    end

    assign label_valid = label_valid_reg;
    assign label       = label_reg;
    assign row_end     = row_end_reg;
    assign frame_end   = frame_end_reg;

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_accept_fills_s1, (pixel_valid && !pixel_stall) |=> s1_valid_reg,
                "accepted pixel did not reach the first stage")
    `ASSERT_CLK(a_s3_held_on_stall, (s3_valid_reg && label_valid_reg && label_stall) |=> s3_valid_reg,
                "sampled code lost while output stalled")
    `ASSERT_NEVER(a_label_range, label_valid_reg && (label_reg > 6'd58),
                  "label outside uniform range")
    `ASSERT_NEVER(a_frame_end_row_end, label_valid_reg && frame_end_reg && !row_end_reg,
                  "frame end without row end")

endmodule
